/* hw/rtl/lgs_pkg.sv */
// Shared types and constants for the Life generation stream block.
`default_nettype none

package lgs_pkg;

   localparam int MAX_WIDTH_DEF     = 1024;
   localparam int MAX_HEIGHT_DEF    = 4096;
   localparam int FRAME_WIDTH_BITS  = 11;
   localparam int FRAME_HEIGHT_BITS = 13;
   localparam int CSR_DATA_W        = 13;
   localparam int FRAME_WIDTH_RESET  = 64;
   localparam int FRAME_HEIGHT_RESET = 64;

   // A byte of zero is a live cell; any other byte is a dead cell.
   localparam logic [7:0] LIVE_BYTE = 8'd0;
   localparam logic [7:0] DEAD_BYTE = 8'd255;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_CELL  = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] cell_value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] next_value;
      logic       end_of_row;
      logic       end_of_frame;
   } rsp_payload_type;

   // One column of the 3x3 window: top is the oldest row.
   typedef struct packed {
      logic [7:0] top;
      logic [7:0] mid;
      logic [7:0] bot;
   } column_type;

   // Which sides of the center cell lie outside the frame.
   typedef struct packed {
      logic first_row;
      logic last_row;
      logic first_col;
      logic last_col;
   } edge_mask_type;

endpackage

`default_nettype wire

/* hw/rtl/lgs_line_buffer.sv */
// Two row line buffers that assemble one window column per pushed cell.
`default_nettype none

module lgs_line_buffer #(
   parameter int DEPTH = lgs_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic [$clog2(DEPTH)-1:0] load_addr,
   input  logic [7:0]               load_byte,
   input  logic                     shift,
   output lgs_pkg::column_type      column
);
   import lgs_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [7:0]    upper_mem  [DEPTH];
   logic [7:0]    middle_mem [DEPTH];

   logic [AW-1:0] addr_ff;
   logic [7:0]    byte_ff;
   logic [7:0]    upper_rd_ff;
   logic [7:0]    middle_rd_ff;
   logic          byp_ff;
   logic [7:0]    byp_upper_ff;
   logic [7:0]    byp_middle_ff;

   // When the held cell is written to the same column that the new cell reads,
   // the read sees the old contents, so the written values are forwarded.
   always_ff @(posedge clock) begin
      if (shift) begin
         middle_mem[addr_ff] <= byte_ff;
         upper_mem[addr_ff]  <= column.mid;
      end
      if (load) begin
         addr_ff       <= load_addr;
         byte_ff       <= load_byte;
         upper_rd_ff   <= upper_mem[load_addr];
         middle_rd_ff  <= middle_mem[load_addr];
         byp_ff        <= shift && (load_addr == addr_ff);
         byp_upper_ff  <= column.mid;
         byp_middle_ff <= byte_ff;
      end
   end

   always_comb begin
      column.top = byp_ff ? byp_upper_ff  : upper_rd_ff;
      column.mid = byp_ff ? byp_middle_ff : middle_rd_ff;
      column.bot = byte_ff;
   end

endmodule

`default_nettype wire

/* hw/rtl/lgs_column_cell.sv */
// One column of the sliding 3x3 window; passes its column to the next cell.
`default_nettype none

module lgs_column_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  lgs_pkg::column_type column_in,
   output lgs_pkg::column_type column_out
);
   import lgs_pkg::*;

   column_type column_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else if (shift) begin
         column_ff <= column_in;
      end
   end

   assign column_out = column_ff;

endmodule

`default_nettype wire

/* hw/rtl/lgs_rule_unit.sv */
// Neighbor count with frame-edge masking and the B3/S23 update of one cell.
`default_nettype none

module lgs_rule_unit (
   input  lgs_pkg::column_type    left_col,
   input  lgs_pkg::column_type    center_col,
   input  lgs_pkg::column_type    right_col,
   input  lgs_pkg::edge_mask_type edges,
   output logic [7:0]             next_value
);
   import lgs_pkg::*;

   logic [7:0] live;
   logic [3:0] count;
   logic [7:0] self_byte;

   always_comb begin
      live[0] = !(edges.first_row || edges.first_col) && (left_col.top == LIVE_BYTE);
      live[1] = !edges.first_col && (left_col.mid == LIVE_BYTE);
      live[2] = !(edges.last_row || edges.first_col) && (left_col.bot == LIVE_BYTE);
      live[3] = !edges.first_row && (center_col.top == LIVE_BYTE);
      live[4] = !edges.last_row && (center_col.bot == LIVE_BYTE);
      live[5] = !(edges.first_row || edges.last_col) && (right_col.top == LIVE_BYTE);
      live[6] = !edges.last_col && (right_col.mid == LIVE_BYTE);
      live[7] = !(edges.last_row || edges.last_col) && (right_col.bot == LIVE_BYTE);

      count = '0;
      for (int i = 0; i < 8; i++) begin
         count = count + 4'(live[i]);
      end

      self_byte = center_col.mid;
      if (self_byte == LIVE_BYTE) begin
         next_value = (count == 4'd2 || count == 4'd3) ? LIVE_BYTE : DEAD_BYTE;
      end else begin
         next_value = (count == 4'd3) ? LIVE_BYTE : self_byte;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/life_generation_stream.sv */
// Top level: one Life generation over a raster-order cell stream.
//
// Requests arrive on req_valid/req_stall/req_payload. A cell request carries
// one cell byte (zero is live); a drain request asks for one pending result.
// Results leave on rsp_valid/rsp_stall/rsp_payload in raster order, one per
// cell, flagged at the end of each row and of the frame.
// The result of a cell appears frame_width+1 cell requests after it; once the
// frame is complete the host sends one drain per pending result. A result is
// valid once the releasing request passes the stage-0, window and output
// registers. Throughput is one request per cycle while req_stall is low: two
// line buffers (one read port and one write port each) feed a chain of three
// column cells. A one-row frame stalls requests while a filler cell is pushed.
// Drains before the frame is complete, drains with nothing pending and cells
// after the frame is complete are accepted and dropped.
// Reset clears the counters and sets width and height to 64; the line
// buffers need no clearing. A register write restarts the frame.
// While rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall is raised.
`default_nettype none

module life_generation_stream #(
   parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lgs_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lgs_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_we,
   input  lgs_pkg::csr_index_type           csr_index,
   input  logic [lgs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lgs_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int PW = $clog2(MAX_WIDTH + 3);
   localparam int RST_W = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
   localparam int RST_H = (FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RESET;

   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [HW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [HW-1:0] out_row_ff, out_row_in;
   logic [PW-1:0] pend_ff, pend_in;
   logic          inject_ff, inject_in;

   logic          valid0_ff;
   logic          emit0_ff;
   edge_mask_type edges0_ff;
   logic          wvalid_ff;
   edge_mask_type edgesw_ff;
   logic          rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   logic          adv;
   logic          accept;
   logic          complete;
   logic          cell_push;
   logic          drain_emit;
   logic          cell_emit;
   logic          emit;
   logic          push;
   logic [7:0]    push_byte;
   logic          in_last_col;
   logic          out_last_col;
   logic          out_last_row;
   logic [PW-1:0] pend_inc;
   edge_mask_type edges_new;
   logic [31:0]   csr_width_val;
   logic [31:0]   csr_height_val;

   column_type    lb_column;
   column_type    right_col;
   column_type    center_col;
   column_type    left_col;
   logic [7:0]    rule_value;

   // The whole pipeline moves together whenever the output register can load.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || inject_ff;
   assign accept    = req_valid && !req_stall;

   assign complete     = (in_row_ff >= height_ff);
   assign in_last_col  = (WW'(in_col_ff) + WW'(1) >= width_ff);
   assign out_last_col = (WW'(out_col_ff) + WW'(1) == width_ff);
   assign out_last_row = (out_row_ff + HW'(1) == height_ff);
   assign pend_inc     = pend_ff + PW'(1);

   assign cell_push  = accept && (req_payload.operation == OP_CELL) && !complete;
   assign drain_emit = accept && (req_payload.operation == OP_DRAIN) && complete
                       && (pend_ff != '0);
   assign cell_emit  = cell_push && (pend_inc > PW'(width_ff) + PW'(1));
   assign emit       = cell_emit || drain_emit;
   // Past the frame, filler cells keep the window moving; they are masked out.
   assign push       = cell_push || drain_emit || (inject_ff && adv);
   assign push_byte  = cell_push ? req_payload.cell_value : DEAD_BYTE;

   always_comb begin
      edges_new.first_row = (out_row_ff == '0);
      edges_new.last_row  = out_last_row;
      edges_new.first_col = (out_col_ff == '0);
      edges_new.last_col  = out_last_col;
   end

   always_comb begin
      csr_width_val  = 32'(csr_wdata[FRAME_WIDTH_BITS-1:0]);
      csr_height_val = 32'(csr_wdata[FRAME_HEIGHT_BITS-1:0]);

      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pend_in    = pend_ff;
      inject_in  = inject_ff;

      if (push) begin
         if (in_last_col) begin
            in_col_in = '0;
            if (!complete) begin
               in_row_in = in_row_ff + HW'(1);
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end

      if (inject_ff && adv) begin
         inject_in = 1'b0;
      end
      // A one-row frame leaves one result fewer pending, so one filler cell
      // is pushed on its own before the drains start.
      if (cell_push && in_last_col && (height_ff == HW'(1))) begin
         inject_in = 1'b1;
      end

      if (cell_push && !cell_emit) begin
         pend_in = pend_inc;
      end else if (drain_emit) begin
         pend_in = pend_ff - PW'(1);
      end

      if (emit) begin
         if (out_last_col) begin
            out_col_in = '0;
            out_row_in = out_row_ff + HW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
         if (out_last_col && out_last_row) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            pend_in    = '0;
            inject_in  = 1'b0;
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               if (csr_width_val == 32'd0) begin
                  width_in = WW'(1);
               end else if (csr_width_val > 32'(MAX_WIDTH)) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = csr_width_val[WW-1:0];
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_height_val == 32'd0) begin
                  height_in = HW'(1);
               end else if (csr_height_val > 32'(MAX_HEIGHT)) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = csr_height_val[HW-1:0];
               end
            end
            default: begin
               width_in = width_ff;
            end
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pend_in    = '0;
         inject_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WW'(RST_W);
         height_ff    <= HW'(RST_H);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         pend_ff      <= '0;
         inject_ff    <= 1'b0;
         valid0_ff    <= 1'b0;
         wvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
         inject_ff  <= inject_in;
         if (adv) begin
            valid0_ff    <= push;
            wvalid_ff    <= valid0_ff && emit0_ff;
            rsp_valid_ff <= wvalid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         emit0_ff  <= emit;
         edges0_ff <= edges_new;
         edgesw_ff <= edges0_ff;
         rsp_payload_ff.next_value   <= rule_value;
         rsp_payload_ff.end_of_row   <= edgesw_ff.last_col;
         rsp_payload_ff.end_of_frame <= edgesw_ff.last_col && edgesw_ff.last_row;
      end
   end

   lgs_line_buffer #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock     (clock),
      .load      (push),
      .load_addr (in_col_ff),
      .load_byte (push_byte),
      .shift     (adv && valid0_ff),
      .column    (lb_column)
   );

   lgs_column_cell u_cell_right (
      .clock      (clock),
      .reset      (reset),
      .shift      (adv && valid0_ff),
      .column_in  (lb_column),
      .column_out (right_col)
   );

   lgs_column_cell u_cell_center (
      .clock      (clock),
      .reset      (reset),
      .shift      (adv && valid0_ff),
      .column_in  (right_col),
      .column_out (center_col)
   );

   lgs_column_cell u_cell_left (
      .clock      (clock),
      .reset      (reset),
      .shift      (adv && valid0_ff),
      .column_in  (center_col),
      .column_out (left_col)
   );

   lgs_rule_unit u_rule (
      .left_col   (left_col),
      .center_col (center_col),
      .right_col  (right_col),
      .edges      (edgesw_ff),
      .next_value (rule_value)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire
